### design/sts_pkg.sv
// Shared types and constants for the sphere triangle subdivider.
// Used by sts_norm and sphere_triangle_subdivider; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int SUM_W   = 17;  // exact sum of two coordinates
  localparam int SQ_W    = 33;  // square of a sum, at most 2^32
  localparam int N_W     = 34;  // sum of three squares
  localparam int REM_W   = 35;  // division remainder after doubling

  // Last emit phase of the four sub-triangles
  localparam logic [1:0] LAST_PHASE = 2'd3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vec3_t;
  typedef vec3_t [2:0] tri_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] p0x;
    logic signed [COORD_W-1:0] p0y;
    logic signed [COORD_W-1:0] p0z;
    logic signed [COORD_W-1:0] p1x;
    logic signed [COORD_W-1:0] p1y;
    logic signed [COORD_W-1:0] p1z;
    logic signed [COORD_W-1:0] p2x;
    logic signed [COORD_W-1:0] p2y;
    logic signed [COORD_W-1:0] p2z;
    logic                      last_of_four;
  } out_item_t;

  // Pipeline depth of one normalizing lane: divide, square root, round
  function automatic int norm_lat(input int frac_bits);
    return (2 * frac_bits + 3) + (frac_bits + 2) + 1;
  endfunction

endpackage

`default_nettype wire

### design/sts_norm.sv
// One normalizing lane: q = round(|s| * 2^F / sqrt(N)) with sign and saturation.
// Pipelined long division, then pipelined square root, one bit per stage.
// Depends on sts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sts_norm #(
  parameter int FRAC_BITS = 14
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire [sts_pkg::SQ_W-1:0]      sq,
  input  wire [sts_pkg::N_W-1:0]       n,
  input  wire                          neg,
  output logic [sts_pkg::COORD_W-1:0]  res
);

  localparam int QW    = 2 * FRAC_BITS + 3;  // quotient bits of sq * 2^(2F+2) / n
  localparam int ROOTW = FRAC_BITS + 2;
  localparam int SRW   = 2 * ROOTW;
  localparam int SREMW = FRAC_BITS + 5;
  localparam int REM_W = sts_pkg::REM_W;
  localparam int N_W   = sts_pkg::N_W;

  logic [REM_W-1:0] drem_r [QW];
  logic [QW-1:0]    dq_r   [QW];
  logic [N_W-1:0]   dn_r   [QW];
  logic [1:0]       flag_r [QW+ROOTW];  // {neg, nonzero length}
  logic [SREMW-1:0] srem_r [ROOTW];
  logic [ROOTW-1:0] root_r [ROOTW];
  logic [SRW-1:0]   sr_r   [ROOTW];
  logic [sts_pkg::COORD_W-1:0] res_r;
  logic [sts_pkg::COORD_W-1:0] res_nxt;

  // Long division: integer bit first, then one fraction bit per stage
  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [REM_W-1:0] x;
    logic [REM_W-1:0] rem_nxt;
    logic [QW-1:0]    q_prev;
    logic [QW-1:0]    q_nxt;
    logic [N_W-1:0]   n_prev;
    logic [1:0]       f_prev;
    logic             ge;
    if (i == 0) begin : g_first
      assign x      = {{(REM_W - sts_pkg::SQ_W){1'b0}}, sq};
      assign q_prev = '0;
      assign n_prev = n;
      assign f_prev = {neg, n != '0};
    end else begin : g_next
      assign x      = {drem_r[i-1][REM_W-2:0], 1'b0};
      assign q_prev = dq_r[i-1];
      assign n_prev = dn_r[i-1];
      assign f_prev = flag_r[i-1];
    end
    assign ge      = x >= {1'b0, n_prev};
    assign rem_nxt = ge ? (x - {1'b0, n_prev}) : x;
    assign q_nxt   = {q_prev[QW-2:0], ge};
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[i] <= rem_nxt;
        dq_r[i]   <= q_nxt;
        dn_r[i]   <= n_prev;
        flag_r[i] <= f_prev;
      end
    end
  end

  // Square root of the quotient, two radicand bits per stage
  for (genvar j = 0; j < ROOTW; j++) begin : g_sqrt
    logic [SREMW-1:0] srem_prev;
    logic [ROOTW-1:0] root_prev;
    logic [SRW-1:0]   sr_prev;
    logic [1:0]       f_prev;
    logic [SREMW-1:0] x;
    logic [SREMW-1:0] t;
    logic             ge;
    logic [SREMW-1:0] srem_nxt;
    logic [ROOTW-1:0] root_nxt;
    logic [SRW-1:0]   sr_nxt;
    if (j == 0) begin : g_first
      assign srem_prev = '0;
      assign root_prev = '0;
      assign sr_prev   = {1'b0, dq_r[QW-1]};
      assign f_prev    = flag_r[QW-1];
    end else begin : g_next
      assign srem_prev = srem_r[j-1];
      assign root_prev = root_r[j-1];
      assign sr_prev   = sr_r[j-1];
      assign f_prev    = flag_r[QW+j-1];
    end
    assign x        = {srem_prev[SREMW-3:0], sr_prev[SRW-1 -: 2]};
    assign t        = {1'b0, root_prev, 2'b01};
    assign ge       = x >= t;
    assign srem_nxt = ge ? (x - t) : x;
    assign root_nxt = {root_prev[ROOTW-2:0], ge};
    assign sr_nxt   = {sr_prev[SRW-3:0], 2'b00};
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[j]    <= srem_nxt;
        root_r[j]    <= root_nxt;
        sr_r[j]      <= sr_nxt;
        flag_r[QW+j] <= f_prev;
      end
    end
  end

  // Round from the root, apply sign, saturate to 16 bits
  always_comb begin
    logic [31:0] q32;
    logic [1:0]  f;
    q32 = (32'(root_r[ROOTW-1]) + 32'd1) >> 1;
    f   = flag_r[QW+ROOTW-1];
    if (!f[0]) begin
      res_nxt = '0;
    end else if (!f[1]) begin
      res_nxt = (q32 > 32'd32767) ? 16'h7fff : q32[15:0];
    end else begin
      res_nxt = (q32 > 32'd32768) ? 16'h8000 : 16'(16'd0 - q32[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

### design/sphere_triangle_subdivider.sv
// An item passes the input register, the sum, square and length stages and a normalizing lane before the emitter.
// The four results of an item share one output port, so the emitter takes a new item only once the last is accepted.
// The datapath pipeline takes an item every cycle unless its last stage holds an item the emitter cannot take.
// Reset clears all valid bits and the emitter; data registers are not reset.
// Depends on sts_pkg and sts_norm.
`timescale 1ns / 1ps
`default_nettype none

module sphere_triangle_subdivider #(
  parameter int FRAC_BITS = 14
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire sts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output sts_pkg::out_item_t  out_data
);

  localparam int LAT   = sts_pkg::norm_lat(FRAC_BITS);
  localparam int DEPTH = 4 + LAT;

  sts_pkg::tri_t tri_in;
  sts_pkg::tri_t vtx_r [DEPTH];
  logic          vld_r [DEPTH];

  logic signed [sts_pkg::SUM_W-1:0] sum_r [9];
  logic [sts_pkg::SQ_W-1:0]         sq3_r [9];
  logic                             neg3_r [9];
  logic [sts_pkg::SQ_W-1:0]         sq4_r [9];
  logic                             neg4_r [9];
  logic [sts_pkg::N_W-1:0]          n4_r  [3];
  sts_pkg::tri_t                    mid;

  logic          en;
  logic          take;
  logic          out_acc;
  logic          em_v_r, em_v_nxt;
  logic [1:0]    phase_r, phase_nxt;
  sts_pkg::tri_t em_tri_r;
  sts_pkg::tri_t em_mid_r;

  // Unpack the input item into vertices
  assign tri_in[0] = {in_data.az, in_data.ay, in_data.ax};
  assign tri_in[1] = {in_data.bz, in_data.by_coord, in_data.bx};
  assign tri_in[2] = {in_data.cz, in_data.cy, in_data.cx};

  // Advance the whole pipeline unless its last item cannot move on
  assign out_acc  = em_v_r && !out_stall;
  assign take     = !em_v_r || (out_acc && (phase_r == sts_pkg::LAST_PHASE));
  assign en       = !vld_r[DEPTH-1] || take;
  assign in_stall = !en;

  // Vertex delay line with valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      vtx_r[0] <= tri_in;
    end
  end
  for (genvar i = 1; i < DEPTH; i++) begin : g_line
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        vtx_r[i] <= vtx_r[i-1];
      end
    end
  end

  // Edge sums, squares and squared lengths; edge 0 = ab, 1 = ac, 2 = bc
  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int P = (e == 2) ? 1 : 0;
    localparam int Q = (e == 0) ? 1 : 2;
    for (genvar k = 0; k < 3; k++) begin : g_comp
      logic signed [sts_pkg::SUM_W-1:0]   sum_nxt;
      logic signed [2*sts_pkg::SUM_W-1:0] prod;
      assign sum_nxt = $signed({vtx_r[0][P][k][15], vtx_r[0][P][k]})
                     + $signed({vtx_r[0][Q][k][15], vtx_r[0][Q][k]});
      assign prod    = sum_r[e*3+k] * sum_r[e*3+k];
      always_ff @(posedge clk) begin
        if (en) begin
          sum_r[e*3+k]  <= sum_nxt;
          sq3_r[e*3+k]  <= prod[sts_pkg::SQ_W-1:0];
          neg3_r[e*3+k] <= sum_r[e*3+k][sts_pkg::SUM_W-1];
          sq4_r[e*3+k]  <= sq3_r[e*3+k];
          neg4_r[e*3+k] <= neg3_r[e*3+k];
        end
      end
      sts_norm #(
        .FRAC_BITS(FRAC_BITS)
      ) u_norm (
        .clk (clk),
        .en  (en),
        .sq  (sq4_r[e*3+k]),
        .n   (n4_r[e]),
        .neg (neg4_r[e*3+k]),
        .res (mid[e][k])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n4_r[e] <= {1'b0, sq3_r[e*3]} + {1'b0, sq3_r[e*3+1]} + {1'b0, sq3_r[e*3+2]};
      end
    end
  end

  // Emitter: hold one item and step through its four sub-triangles
  always_comb begin
    em_v_nxt  = em_v_r;
    phase_nxt = phase_r;
    if (take) begin
      em_v_nxt  = vld_r[DEPTH-1];
      phase_nxt = 2'd0;
    end else if (out_acc) begin
      phase_nxt = phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_v_r  <= 1'b0;
      phase_r <= 2'd0;
    end else begin
      em_v_r  <= em_v_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && vld_r[DEPTH-1]) begin
      em_tri_r <= vtx_r[DEPTH-1];
      em_mid_r <= mid;
    end
  end

  // Select the vertices of the current sub-triangle
  always_comb begin
    sts_pkg::vec3_t v0, v1, v2;
    case (phase_r)
      2'd0: begin
        v0 = em_mid_r[0]; v1 = em_mid_r[2]; v2 = em_mid_r[1];
      end
      2'd1: begin
        v0 = em_tri_r[0]; v1 = em_mid_r[0]; v2 = em_mid_r[1];
      end
      2'd2: begin
        v0 = em_tri_r[2]; v1 = em_mid_r[1]; v2 = em_mid_r[2];
      end
      default: begin
        v0 = em_tri_r[1]; v1 = em_mid_r[2]; v2 = em_mid_r[0];
      end
    endcase
    out_data.p0x          = v0[0];
    out_data.p0y          = v0[1];
    out_data.p0z          = v0[2];
    out_data.p1x          = v1[0];
    out_data.p1y          = v1[1];
    out_data.p1z          = v1[2];
    out_data.p2x          = v2[0];
    out_data.p2y          = v2[1];
    out_data.p2z          = v2[2];
    out_data.last_of_four = (phase_r == sts_pkg::LAST_PHASE);
  end

  assign out_valid = em_v_r;

  // An item in the emitter is not dropped before its fourth result
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    em_v_r && (phase_r != sts_pkg::LAST_PHASE) |=> em_v_r)
    else $error("emitter lost an item before its last result");

  // A handoff from the pipeline always starts at the first sub-triangle
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[DEPTH-1] |=> em_v_r && (phase_r == 2'd0))
    else $error("handoff did not start at phase zero");

  // A stalled result keeps its phase
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    em_v_r && out_stall |=> $stable(phase_r))
    else $error("phase moved under stall");

endmodule

`default_nettype wire
